>>> sv/dgcc_pkg.sv
// ----------------------------------------------------------------------------
// dgcc_pkg
// Shared constants and types for the directed graph cycle check block.
// ----------------------------------------------------------------------------
package dgcc_pkg;

    localparam int MAX_V = 16;
    localparam int VTX_W = $clog2(MAX_V);
    localparam int CNT_W = VTX_W + 1;
    localparam int CMD_W = 2;

    typedef logic [MAX_V-1:0] t_row;
    typedef logic [VTX_W-1:0] t_vtx;
    typedef logic [CNT_W-1:0] t_cnt;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    localparam t_cnt CNT_RESET = t_cnt'(MAX_V);

    // walk sequencer status toward the top level
    typedef struct packed {
        logic busy;
        logic done;
        logic cycle;
    } t_walk_stat;

endpackage

>>> sv/dgcc_scan.sv
// ----------------------------------------------------------------------------
// dgcc_scan
// Next-edge finder: lowest set bit of an adjacency row at or above a start.
// ----------------------------------------------------------------------------
module dgcc_scan
    import dgcc_pkg::*;
(
    input  t_row i_row,
    input  t_cnt i_from,
    output logic o_found,
    output t_vtx o_index
);

    t_row w_rest;

    always_comb begin
        for (int i = 0; i < MAX_V; i++) begin
            w_rest[i] = i_row[i] && (t_cnt'(i) >= i_from);
        end
    end

    always_comb begin
        o_index = '0;
        for (int i = MAX_V - 1; i >= 0; i--) begin
            if (w_rest[i]) begin
                o_index = t_vtx'(i);
            end
        end
    end

    assign o_found = |w_rest;

endmodule

>>> sv/dgcc_walk.sv
// ----------------------------------------------------------------------------
// dgcc_walk
// Depth-first walk sequencer with explicit stack and path/finished marks.
// ----------------------------------------------------------------------------
module dgcc_walk
    import dgcc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_take,
    input  t_cnt       i_count,
    input  t_row       i_row,
    output t_vtx       o_row_addr,
    output t_walk_stat o_stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_STEP,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    t_row   r_on_path, n_on_path;
    t_row   r_fin, n_fin;
    t_cnt   r_depth, n_depth;
    t_cnt   r_start, n_start;
    logic   r_cycle, n_cycle;

    t_vtx   r_stk_v [MAX_V];
    t_cnt   r_stk_s [MAX_V];

    t_vtx   w_top;
    t_vtx   w_v;
    t_cnt   w_s;
    logic   w_found;
    t_vtx   w_w;

    logic   w_push;
    t_vtx   w_push_at;
    t_vtx   w_push_v;
    logic   w_scan_wr;

    assign w_top      = r_depth[VTX_W-1:0] - t_vtx'(1);
    assign w_v        = r_stk_v[w_top];
    assign w_s        = r_stk_s[w_top];
    assign o_row_addr = w_v;

    dgcc_scan u_scan (
        .i_row   (i_row),
        .i_from  (w_s),
        .o_found (w_found),
        .o_index (w_w)
    );

    always_comb begin
        n_state   = r_state;
        n_on_path = r_on_path;
        n_fin     = r_fin;
        n_depth   = r_depth;
        n_start   = r_start;
        n_cycle   = r_cycle;
        w_push    = 1'b0;
        w_push_at = '0;
        w_push_v  = '0;
        w_scan_wr = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_on_path = '0;
                    n_fin     = '0;
                    n_start   = '0;
                    n_depth   = '0;
                    n_state   = S_START;
                end
            end
            S_START: begin
                if (r_start >= i_count) begin
                    n_cycle = 1'b0;
                    n_state = S_DONE;
                end else if (r_fin[r_start[VTX_W-1:0]]) begin
                    n_start = r_start + t_cnt'(1);
                end else begin
                    w_push    = 1'b1;
                    w_push_at = '0;
                    w_push_v  = r_start[VTX_W-1:0];
                    n_on_path[r_start[VTX_W-1:0]] = 1'b1;
                    n_depth   = t_cnt'(1);
                    n_state   = S_STEP;
                end
            end
            S_STEP: begin
                if (!w_found) begin
                    // row exhausted: retire vertex, pop
                    n_on_path[w_v] = 1'b0;
                    n_fin[w_v]     = 1'b1;
                    n_depth        = r_depth - t_cnt'(1);
                    if (r_depth == t_cnt'(1)) begin
                        n_state = S_START;
                    end
                end else begin
                    w_scan_wr = 1'b1;
                    if (r_on_path[w_w]) begin
                        n_cycle = 1'b1;
                        n_state = S_DONE;
                    end else if (!r_fin[w_w] && r_depth < t_cnt'(MAX_V)) begin
                        w_push         = 1'b1;
                        w_push_at      = r_depth[VTX_W-1:0];
                        w_push_v       = w_w;
                        n_on_path[w_w] = 1'b1;
                        n_depth        = r_depth + t_cnt'(1);
                    end
                end
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_on_path <= '0;
            r_fin     <= '0;
            r_depth   <= '0;
            r_start   <= '0;
            r_cycle   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_on_path <= n_on_path;
            r_fin     <= n_fin;
            r_depth   <= n_depth;
            r_start   <= n_start;
            r_cycle   <= n_cycle;
        end
    end

    // stack entries need no reset: always pushed before read
    always_ff @(posedge i_clk) begin
        if (w_scan_wr) begin
            r_stk_s[w_top] <= t_cnt'(w_w) + t_cnt'(1);
        end
        if (w_push) begin
            r_stk_v[w_push_at] <= w_push_v;
            r_stk_s[w_push_at] <= '0;
        end
    end

    assign o_stat.busy  = (r_state != S_IDLE);
    assign o_stat.done  = (r_state == S_DONE);
    assign o_stat.cycle = r_cycle;

    a_depth_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= t_cnt'(MAX_V))
        else $error("walk stack depth above limit");

    a_step_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_STEP |-> r_depth != '0)
        else $error("step with empty stack");

    a_marks_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_on_path & r_fin) == '0)
        else $error("vertex both on path and finished");

    a_path_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_STEP |-> $countones(r_on_path) == int'(r_depth))
        else $error("path marks disagree with stack depth");

    a_start_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE && i_start |=> r_state == S_START)
        else $error("query did not begin walk");

endmodule

>>> sv/directed_graph_cycle_check.sv
// ----------------------------------------------------------------------------
// directed_graph_cycle_check
// Adjacency matrix store with a depth-first cycle search on query.
// ----------------------------------------------------------------------------
// Clear and add-edge beats give no result. A query beat runs a marked
// depth-first walk through the stored 16x16 adjacency matrix, one row scan
// per cycle in a single next-edge finder, and the input is not ready until
// the walk ends; the walk stops early when a cycle is found. The result
// beat sits in an output register, so further beats are taken while it
// waits. Edges naming a vertex at or beyond the count are dropped; a count
// above 16 acts as 16.
module directed_graph_cycle_check
    import dgcc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CNT_W-1:0] i_cfg_wr_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [CMD_W-1:0] i_command,
    input  logic [VTX_W-1:0] i_from_vertex,
    input  logic [VTX_W-1:0] i_to_vertex,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_has_cycle
);

    t_cnt       r_vcount;
    t_row       r_adj [MAX_V];
    logic       r_out_valid;
    logic       r_has_cycle;

    t_cnt       w_n;
    t_row       w_keep;
    t_vtx       w_row_addr;
    t_row       w_row;
    t_walk_stat w_stat;
    logic       w_acc;
    logic       w_take;
    logic       w_add;

    assign w_n = (r_vcount > t_cnt'(MAX_V)) ? t_cnt'(MAX_V) : r_vcount;

    always_comb begin
        for (int i = 0; i < MAX_V; i++) begin
            w_keep[i] = t_cnt'(i) < w_n;
        end
    end

    assign w_row  = r_adj[w_row_addr] & w_keep;
    assign w_acc  = i_in_valid && o_in_ready;
    assign w_take = w_stat.done && (!r_out_valid || i_out_ready);
    assign w_add  = w_acc && (i_command == CMD_ADD)
                    && (t_cnt'(i_from_vertex) < w_n) && (t_cnt'(i_to_vertex) < w_n);

    dgcc_walk u_walk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_acc && (i_command == CMD_QUERY)),
        .i_take     (w_take),
        .i_count    (w_n),
        .i_row      (w_row),
        .o_row_addr (w_row_addr),
        .o_stat     (w_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= CNT_RESET;
        end else if (i_cfg_wr_en) begin
            r_vcount <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_V; i++) begin
                r_adj[i] <= '0;
            end
        end else if (w_acc && (i_command == CMD_CLEAR)) begin
            for (int i = 0; i < MAX_V; i++) begin
                r_adj[i] <= '0;
            end
        end else if (w_add) begin
            r_adj[i_from_vertex][i_to_vertex] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_has_cycle <= w_stat.cycle;
        end
    end

    assign o_in_ready  = !w_stat.busy;
    assign o_out_valid = r_out_valid;
    assign o_has_cycle = r_has_cycle;

endmodule

>>> tb/directed_graph_cycle_check_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// directed_graph_cycle_check_test
// Self-checking bench for the graph cycle check block. Edge loads, clears and
// queries are streamed in over valid/ready with random idle bursts on both
// sides. A scoreboard keeps its own adjacency matrix and vertex count and
// predicts every query answer by peeling off vertices without live successors.
// ----------------------------------------------------------------------------
module directed_graph_cycle_check_test
    import dgcc_pkg::*;
;

    class cycle_verdicts;
        t_row adj [MAX_V];
        t_cnt count;
        bit   due [$];
        int   errors;

        function new();
            count  = CNT_RESET;
            errors = 0;
            foreach (adj[i]) adj[i] = '0;
        endfunction

        function int eff_count();
            return (count > MAX_V) ? MAX_V : int'(count);
        endfunction

        function void set_count(t_cnt value);
            count = value;
        endfunction

        function int pending();
            return due.size();
        endfunction

        // a graph is acyclic iff repeatedly dropping sinks empties it
        function bit loop_present();
            int   n;
            t_row live;
            bit   changed;
            n    = eff_count();
            live = (n >= MAX_V) ? '1 : t_row'((1 << n) - 1);
            do begin
                changed = 1'b0;
                for (int v = 0; v < MAX_V; v++) begin
                    if (live[v] && (adj[v] & live) == '0) begin
                        live[v] = 1'b0;
                        changed = 1'b1;
                    end
                end
            end while (changed);
            return live != '0;
        endfunction

        function void take_beat(logic [CMD_W-1:0] cmd, t_vtx src, t_vtx dst);
            int n;
            n = eff_count();
            case (cmd)
                CMD_CLEAR: begin
                    foreach (adj[i]) adj[i] = '0;
                end
                CMD_ADD: begin
                    if (src < n && dst < n) adj[src][dst] = 1'b1;
                end
                CMD_QUERY: begin
                    due.insert(due.size(), loop_present());
                end
                default: ;
            endcase
        endfunction

        function void match_answer(logic got);
            bit want;
            if (due.size() == 0) begin
                $error("has_cycle: result beat with no query pending, actual %0b", got);
                errors++;
                return;
            end
            want = due.pop_front();
            if (got !== want) begin
                $error("has_cycle mismatch: expected %0b, actual %0b", want, got);
                errors++;
            end
        endfunction
    endclass

    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;  // unused code, block ignores it
    localparam int RANDOM_BEATS   = 1300;
    localparam int PHASE_BEATS    = 120;
    localparam int CALM_BEATS     = 200;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 4000;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_cfg_wr_en   = 1'b0;
    logic [CNT_W-1:0] i_cfg_wr_data = '0;
    logic             i_in_valid    = 1'b0;
    logic             o_in_ready;
    logic [CMD_W-1:0] i_command     = CMD_CLEAR;
    logic [VTX_W-1:0] i_from_vertex = '0;
    logic [VTX_W-1:0] i_to_vertex   = '0;
    logic             o_out_valid;
    logic             i_out_ready   = 1'b0;
    logic             o_has_cycle;

    cycle_verdicts book;
    bit idle_on     = 1'b1;
    int real_beats  = 0;
    int stall_left  = 0;
    int quiet_count = 0;

    directed_graph_cycle_check u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_from_vertex(i_from_vertex),
        .i_to_vertex  (i_to_vertex),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_has_cycle  (o_has_cycle)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: random back-pressure bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= (stall_left == 1);
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left  <= $urandom_range(1, 7);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready)
            book.match_answer(o_has_cycle);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready === 1'b1) ||
            (o_out_valid === 1'b1 && i_out_ready)) begin
            quiet_count <= 0;
        end else begin
            quiet_count <= quiet_count + 1;
            if (quiet_count == WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    function automatic t_vtx rnd_vtx();
        return t_vtx'($urandom_range(0, MAX_V - 1));
    endfunction

    function automatic t_vtx in_vtx(int n);
        return (n == 0) ? rnd_vtx() : t_vtx'($urandom_range(0, n - 1));
    endfunction

    function automatic t_vtx far_vtx(int n);
        return (n >= MAX_V) ? rnd_vtx() : t_vtx'($urandom_range(n, MAX_V - 1));
    endfunction

    function automatic t_cnt pick_count(int phase);
        case (phase)
            0: return t_cnt'(16);
            1: return t_cnt'(1);
            2: return t_cnt'(0);
            3: return t_cnt'(31);
            4: return t_cnt'(2);
            5: return t_cnt'(17);
            default: begin
                if ($urandom_range(0, 9) == 0) return t_cnt'($urandom_range(0, 31));
                return t_cnt'($urandom_range(1, 16));
            end
        endcase
    endfunction

    task automatic push_beat(input logic [CMD_W-1:0] cmd, input t_vtx src, input t_vtx dst);
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_from_vertex <= src;
        i_to_vertex   <= dst;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        book.take_beat(cmd, src, dst);
        real_beats++;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    // stop sending and let every outstanding answer drain
    task automatic settle();
        i_in_valid <= 1'b0;
        while (book.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_count(input t_cnt value);
        settle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        book.set_count(value);
    endtask

    // one graph: optional clear, a batch of edges in some shape, then a query
    task automatic graph_round();
        int n, style, edges, pick, a, b;
        n     = book.eff_count();
        style = (n < 2) ? 0 : $urandom_range(0, 3);
        edges = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3 * n) :
                                              $urandom_range(0, n + 2);
        if ($urandom_range(0, 4) != 0) push_beat(CMD_CLEAR, rnd_vtx(), rnd_vtx());
        repeat (edges) begin
            pick = $urandom_range(0, 11);
            if (pick == 0) begin
                push_beat(CMD_NONE, rnd_vtx(), rnd_vtx());
            end else if (pick == 1) begin
                push_beat(CMD_QUERY, rnd_vtx(), rnd_vtx());
            end else if (pick == 2) begin
                if ($urandom_range(0, 1)) push_beat(CMD_ADD, far_vtx(n), rnd_vtx());
                else                      push_beat(CMD_ADD, rnd_vtx(), far_vtx(n));
            end else begin
                a = in_vtx(n);
                b = in_vtx(n);
                if (style != 0 && a == b) b = (a + 1) % n;
                // styles 1..3 keep this batch's edges acyclic by ordering them
                if ((style == 1 || style == 2) && a > b) {a, b} = {b, a};
                else if (style == 3 && a < b) {a, b} = {b, a};
                push_beat(CMD_ADD, t_vtx'(a), t_vtx'(b));
            end
        end
        if (style == 2) begin
            // back edge or self-loop; may or may not close a cycle
            a = in_vtx(n);
            b = in_vtx(n);
            if (a < b) {a, b} = {b, a};
            push_beat(CMD_ADD, t_vtx'(a), t_vtx'(b));
        end
        push_beat(CMD_QUERY, rnd_vtx(), rnd_vtx());
    endtask

    initial begin
        int phase, phase_end;
        book = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty graph, extreme vertices, self-loop, unused code
        push_beat(CMD_QUERY, 4'd15, 4'd15);
        push_beat(CMD_ADD,   4'd0,  4'd15);
        push_beat(CMD_QUERY, 4'd0,  4'd0);
        push_beat(CMD_ADD,   4'd15, 4'd0);
        push_beat(CMD_QUERY, 4'd0,  4'd0);
        push_beat(CMD_CLEAR, 4'd15, 4'd15);
        push_beat(CMD_QUERY, 4'd0,  4'd0);
        push_beat(CMD_ADD,   4'd15, 4'd15);
        push_beat(CMD_QUERY, 4'd0,  4'd0);
        push_beat(CMD_CLEAR, 4'd0,  4'd0);
        push_beat(CMD_NONE,  4'd15, 4'd15);
        push_beat(CMD_QUERY, 4'd0,  4'd0);
        push_beat(CMD_ADD,   4'd0,  4'd1);
        push_beat(CMD_ADD,   4'd1,  4'd2);
        push_beat(CMD_ADD,   4'd2,  4'd0);
        push_beat(CMD_ADD,   4'd9,  4'd10);
        push_beat(CMD_ADD,   4'd10, 4'd9);
        push_beat(CMD_QUERY, 4'd0,  4'd0);
        // count lowered after loading: only 0->1 survives
        write_count(t_cnt'(2));
        push_beat(CMD_QUERY, 4'd0,  4'd0);
        push_beat(CMD_ADD,   4'd3,  4'd1);
        push_beat(CMD_QUERY, 4'd0,  4'd0);
        // no vertices at all
        write_count(t_cnt'(0));
        push_beat(CMD_ADD,   4'd0,  4'd0);
        push_beat(CMD_QUERY, 4'd0,  4'd0);
        // above the limit acts as full size
        write_count(t_cnt'(31));
        push_beat(CMD_QUERY, 4'd0,  4'd0);
        write_count(t_cnt'(1));
        push_beat(CMD_ADD,   4'd0,  4'd0);
        push_beat(CMD_QUERY, 4'd0,  4'd0);

        real_beats = 0;
        phase      = 0;
        while (real_beats < RANDOM_BEATS) begin
            write_count(pick_count(phase));
            idle_on   = ($urandom_range(0, 3) != 0);
            phase_end = real_beats + PHASE_BEATS;
            while (real_beats < phase_end && real_beats < RANDOM_BEATS) begin
                if (real_beats >= RANDOM_BEATS - CALM_BEATS) idle_on = 1'b0;
                graph_round();
            end
            phase++;
        end

        settle();
        if (book.errors == 0 && book.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
